// ----- design/ehdd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge hotspot dwell detector package
// Shared widths, command and event codes, register indexes, FSM state type
// and the result item type.
// ----------------------------------------------------------------------------
package ehdd_pkg;

   localparam int unsigned CSR_INDEX_BITS = 4;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned CMD_BITS       = 2;
   localparam int unsigned EVENT_BITS     = 2;
   localparam int unsigned DIM_BITS       = 15;
   localparam int unsigned DWELL_BITS     = 16;
   localparam int unsigned HALF_BITS      = 16;
   localparam int unsigned DIST_BITS      = 16;
   localparam int unsigned RAD_BITS       = 32;
   localparam int unsigned REM_BITS       = 18;
   localparam int unsigned ITER_BITS      = 4;

   localparam logic [CMD_BITS-1:0] CMD_MOTION = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_GONE   = 2'd2;

   localparam logic [EVENT_BITS-1:0] EV_ENTER = 2'd0;
   localparam logic [EVENT_BITS-1:0] EV_LEAVE = 2'd1;
   localparam logic [EVENT_BITS-1:0] EV_PROX  = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIG_X      = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIG_Y      = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIG_W      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRIG_H      = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESH      = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DWELL_TICKS = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUT_ORIGIN  = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OUT_SIZE    = 4'd7;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE,
      S_CMP,
      S_CLAMP,
      S_SQ_X,
      S_SQ_Y,
      S_SUM,
      S_ROOT,
      S_DECIDE,
      S_EMIT
   } ehdd_state_type;

   typedef struct packed {
      logic [EVENT_BITS-1:0] event_code;
      logic [DIM_BITS-1:0]   proximity;
      logic                  last_of_run;
   } ehdd_item_type;

endpackage

// ----- design/ehdd_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Pointer command item: command code and pointer position.
// ----------------------------------------------------------------------------
interface ehdd_req_if #(
   parameter int COORD_BITS = 16
);
   logic                                  valid;
   logic                                  ready;
   logic [ehdd_pkg::CMD_BITS-1:0]         cmd;
   logic signed [COORD_BITS-1:0]          pos_x;
   logic signed [COORD_BITS-1:0]          pos_y;

   modport source (output valid, output cmd, output pos_x, output pos_y, input ready);
   modport sink (input valid, input cmd, input pos_x, input pos_y, output ready);
endinterface

// ----- design/ehdd_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Event item: event code, proximity and end-of-run flag.
// ----------------------------------------------------------------------------
interface ehdd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ehdd_pkg::EVENT_BITS-1:0]   event_code;
   logic [ehdd_pkg::DIM_BITS-1:0]     proximity;
   logic                              last_of_run;

   modport source (output valid, output event_code, output proximity, output last_of_run,
                   input ready);
   modport sink (input valid, input event_code, input proximity, input last_of_run,
                 output ready);
endinterface

// ----- design/ehdd_csr_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface ehdd_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [ehdd_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [ehdd_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/ehdd_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial integer square root
// Floor square root of a 32-bit radicand, two radicand bits shifted in and
// one root bit decided per cycle; done pulses after the last step.
// ----------------------------------------------------------------------------
module ehdd_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ehdd_pkg::RAD_BITS-1:0]       radicand,
   output logic                                done,
   output logic [ehdd_pkg::DIST_BITS-1:0]      root
);
   logic [ehdd_pkg::RAD_BITS-1:0]  rad_ff, rad_in;
   logic [ehdd_pkg::REM_BITS-1:0]  rem_ff, rem_in;
   logic [ehdd_pkg::DIST_BITS-1:0] root_ff, root_in;
   logic [ehdd_pkg::ITER_BITS-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [ehdd_pkg::REM_BITS-1:0]  rem_sh;
   logic [ehdd_pkg::REM_BITS-1:0]  trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[ehdd_pkg::REM_BITS-3:0], rad_ff[ehdd_pkg::RAD_BITS-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[ehdd_pkg::RAD_BITS-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ehdd_pkg::DIST_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ehdd_pkg::DIST_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- design/edge_hotspot_dwell_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge hotspot dwell detector
// Checks pointer motion against a trigger rectangle grown by a threshold and
// clipped to the output, runs a dwell timer on millisecond ticks and reports
// enter, leave and proximity events.
//
//   channel  | dir | handshake        | contents
//   ---------+-----+------------------+--------------------------------------
//   req_ch   | in  | valid / ready    | cmd, pos_x, pos_y
//   rsp_ch   | out | valid / ready    | event_code, proximity, last_of_run
//   csr_ch   | in  | valid / ready    | index, data (register write)
//
// One item at a time. A motion or a timer fire runs the edge, compare, clamp
// and square-x states, then square-y, sum and the 16-step serial square root
// only when the point lies off a trigger corner, then decide and an emit per
// result; other ticks end in idle, and output removal too unless it emits a leave.
// Reset clears configuration, tracking state but the fire flag, and result valid;
// the datapath registers are not reset, and no channel is ready during reset.
// The next item is taken while the last result waits in the output register;
// a stalled result channel holds the remaining results of an item and the input.
// ----------------------------------------------------------------------------
module edge_hotspot_dwell_detector #(
   parameter int COORD_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ehdd_req_if.sink   req_ch,
   ehdd_rsp_if.source rsp_ch,
   ehdd_csr_if.sink   csr_ch
);
   localparam int EW = ((COORD_BITS > 17) ? COORD_BITS : 17) + 3;
   localparam int DB = ehdd_pkg::DIST_BITS;
   localparam int WB = ehdd_pkg::DIM_BITS;
   localparam int HB = ehdd_pkg::HALF_BITS;

   // configuration
   logic [COORD_BITS-1:0]               trig_x_ff, trig_x_in;
   logic [COORD_BITS-1:0]               trig_y_ff, trig_y_in;
   logic [WB-1:0]                       trig_w_ff, trig_w_in;
   logic [WB-1:0]                       trig_h_ff, trig_h_in;
   logic [WB-1:0]                       thresh_ff, thresh_in;
   logic [ehdd_pkg::DWELL_BITS-1:0]     dwell_ff, dwell_in;
   logic [ehdd_pkg::CSR_DATA_BITS-1:0]  origin_ff, origin_in;
   logic [ehdd_pkg::CSR_DATA_BITS-1:0]  size_ff, size_in;

   // tracking state
   ehdd_pkg::ehdd_state_type            state_ff, state_in;
   logic                                entered_ff, entered_in;
   logic                                armed_ff, armed_in;
   logic                                gone_ff, gone_in;
   logic [ehdd_pkg::DWELL_BITS-1:0]     left_ff, left_in;
   logic [COORD_BITS-1:0]               ax_ff, ax_in;
   logic [COORD_BITS-1:0]               ay_ff, ay_in;
   logic                                fire_ff, fire_in;

   // distance datapath
   logic [COORD_BITS-1:0]               pt_x_ff, pt_x_in;
   logic [COORD_BITS-1:0]               pt_y_ff, pt_y_in;
   logic signed [EW-1:0]                lo_x_ff, lo_x_in, hi_x_ff, hi_x_in;
   logic signed [EW-1:0]                lo_y_ff, lo_y_in, hi_y_ff, hi_y_in;
   logic signed [EW-1:0]                rx_ff, rx_in, by_ff, by_in;
   logic signed [EW-1:0]                oxh_ff, oxh_in, oyh_ff, oyh_in;
   logic                                box_ff, box_in;
   logic signed [EW-1:0]                dxr_ff, dxr_in, dyr_ff, dyr_in;
   logic [DB-1:0]                       dx_ff, dx_in, dy_ff, dy_in;
   logic [ehdd_pkg::RAD_BITS-1:0]       sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [DB-1:0]                       dist_ff, dist_in;

   // result queue and output register
   ehdd_pkg::ehdd_item_type             q_ff [2];
   ehdd_pkg::ehdd_item_type             q_in [2];
   logic [1:0]                          qcnt_ff, qcnt_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ehdd_pkg::ehdd_item_type             rsp_item_ff, rsp_item_in;

   // combinational helpers
   logic signed [EW-1:0] tx_e, ty_e, tw_e, th_e, t_e, lim_e;
   logic signed [EW-1:0] ox_e, oy_e, ow_e, oh_e, px_e, py_e;
   logic [DB-1:0]        mul_op;
   logic [ehdd_pkg::RAD_BITS-1:0] mul_res;
   logic                 req_ready;
   logic                 out_free;
   logic                 in_reach;
   logic                 hot;
   logic [WB-1:0]        capped;
   logic                 root_start;
   logic                 root_done;
   logic [DB-1:0]        root_val;

   ehdd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_x_ff + sq_y_ff),
      .done     (root_done),
      .root     (root_val)
   );

   assign tx_e  = {{(EW-COORD_BITS){trig_x_ff[COORD_BITS-1]}}, trig_x_ff};
   assign ty_e  = {{(EW-COORD_BITS){trig_y_ff[COORD_BITS-1]}}, trig_y_ff};
   assign tw_e  = {{(EW-WB){1'b0}}, trig_w_ff};
   assign th_e  = {{(EW-WB){1'b0}}, trig_h_ff};
   assign t_e   = {{(EW-WB){1'b0}}, thresh_ff};
   assign lim_e = t_e + EW'(1);
   assign ox_e  = {{(EW-HB){origin_ff[2*HB-1]}}, origin_ff[2*HB-1:HB]};
   assign oy_e  = {{(EW-HB){origin_ff[HB-1]}}, origin_ff[HB-1:0]};
   assign ow_e  = {{(EW-HB){1'b0}}, size_ff[2*HB-1:HB]};
   assign oh_e  = {{(EW-HB){1'b0}}, size_ff[HB-1:0]};
   assign px_e  = {{(EW-COORD_BITS){pt_x_ff[COORD_BITS-1]}}, pt_x_ff};
   assign py_e  = {{(EW-COORD_BITS){pt_y_ff[COORD_BITS-1]}}, pt_y_ff};

   assign mul_op  = (state_ff == ehdd_pkg::S_SQ_Y) ? dy_ff : dx_ff;
   assign mul_res = ehdd_pkg::RAD_BITS'(mul_op) * ehdd_pkg::RAD_BITS'(mul_op);

   assign in_reach = dist_ff <= {1'b0, thresh_ff};
   assign capped   = in_reach ? dist_ff[WB-1:0] : thresh_ff;
   assign hot      = !gone_ff && box_ff && in_reach;

   // register writes
   always_comb begin
      trig_x_in = trig_x_ff;
      trig_y_in = trig_y_ff;
      trig_w_in = trig_w_ff;
      trig_h_in = trig_h_ff;
      thresh_in = thresh_ff;
      dwell_in  = dwell_ff;
      origin_in = origin_ff;
      size_in   = size_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            ehdd_pkg::REG_TRIG_X:      trig_x_in = csr_ch.data[COORD_BITS-1:0];
            ehdd_pkg::REG_TRIG_Y:      trig_y_in = csr_ch.data[COORD_BITS-1:0];
            ehdd_pkg::REG_TRIG_W:      trig_w_in = csr_ch.data[WB-1:0];
            ehdd_pkg::REG_TRIG_H:      trig_h_in = csr_ch.data[WB-1:0];
            ehdd_pkg::REG_THRESH:      thresh_in = csr_ch.data[WB-1:0];
            ehdd_pkg::REG_DWELL_TICKS: dwell_in  = csr_ch.data[ehdd_pkg::DWELL_BITS-1:0];
            ehdd_pkg::REG_OUT_ORIGIN:  origin_in = csr_ch.data;
            ehdd_pkg::REG_OUT_SIZE:    size_in   = csr_ch.data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      entered_in   = entered_ff;
      armed_in     = armed_ff;
      gone_in      = gone_ff;
      left_in      = left_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      fire_in      = fire_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      lo_x_in      = lo_x_ff;
      hi_x_in      = hi_x_ff;
      lo_y_in      = lo_y_ff;
      hi_y_in      = hi_y_ff;
      rx_in        = rx_ff;
      by_in        = by_ff;
      oxh_in       = oxh_ff;
      oyh_in       = oyh_ff;
      box_in       = box_ff;
      dxr_in       = dxr_ff;
      dyr_in       = dyr_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_x_in      = sq_x_ff;
      sq_y_in      = sq_y_ff;
      dist_in      = dist_ff;
      q_in[0]      = q_ff[0];
      q_in[1]      = q_ff[1];
      qcnt_in      = qcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      req_ready    = 1'b0;
      root_start   = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ch.ready;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ehdd_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               unique case (req_ch.cmd)
                  ehdd_pkg::CMD_MOTION: begin
                     pt_x_in  = req_ch.pos_x;
                     pt_y_in  = req_ch.pos_y;
                     fire_in  = 1'b0;
                     state_in = ehdd_pkg::S_EDGE;
                  end
                  ehdd_pkg::CMD_TICK: begin
                     if (armed_ff) begin
                        if (left_ff <= ehdd_pkg::DWELL_BITS'(1)) begin
                           pt_x_in  = ax_ff;
                           pt_y_in  = ay_ff;
                           fire_in  = 1'b1;
                           state_in = ehdd_pkg::S_EDGE;
                        end else begin
                           left_in = left_ff - 1'b1;
                        end
                     end
                  end
                  ehdd_pkg::CMD_GONE: begin
                     gone_in  = 1'b1;
                     armed_in = 1'b0;
                     if (entered_ff) begin
                        entered_in = 1'b0;
                        q_in[0]    = '{event_code: ehdd_pkg::EV_LEAVE,
                                       proximity: '0, last_of_run: 1'b1};
                        qcnt_in    = 2'd1;
                        state_in   = ehdd_pkg::S_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ehdd_pkg::S_EDGE: begin
            lo_x_in  = tx_e - t_e;
            hi_x_in  = tx_e + tw_e + t_e;
            rx_in    = tx_e + tw_e;
            oxh_in   = ox_e + ow_e;
            lo_y_in  = ty_e - t_e;
            hi_y_in  = ty_e + th_e + t_e;
            by_in    = ty_e + th_e;
            oyh_in   = oy_e + oh_e;
            state_in = ehdd_pkg::S_CMP;
         end
         ehdd_pkg::S_CMP: begin
            box_in = (px_e >= lo_x_ff) && (px_e < hi_x_ff) && (px_e >= ox_e) &&
                     (px_e < oxh_ff) && (py_e >= lo_y_ff) && (py_e < hi_y_ff) &&
                     (py_e >= oy_e) && (py_e < oyh_ff);
            if (px_e < tx_e) begin
               dxr_in = tx_e - px_e;
            end else if ((trig_w_ff != '0) && (px_e > rx_ff)) begin
               dxr_in = px_e - rx_ff;
            end else begin
               dxr_in = '0;
            end
            if (py_e < ty_e) begin
               dyr_in = ty_e - py_e;
            end else if ((trig_h_ff != '0) && (py_e > by_ff)) begin
               dyr_in = py_e - by_ff;
            end else begin
               dyr_in = '0;
            end
            state_in = ehdd_pkg::S_CLAMP;
         end
         ehdd_pkg::S_CLAMP: begin
            dx_in    = (dxr_ff > lim_e) ? lim_e[DB-1:0] : dxr_ff[DB-1:0];
            dy_in    = (dyr_ff > lim_e) ? lim_e[DB-1:0] : dyr_ff[DB-1:0];
            state_in = ehdd_pkg::S_SQ_X;
         end
         ehdd_pkg::S_SQ_X: begin
            if ((dx_ff == '0) || (dy_ff == '0)) begin
               dist_in  = dx_ff | dy_ff;
               state_in = ehdd_pkg::S_DECIDE;
            end else begin
               sq_x_in  = mul_res;
               state_in = ehdd_pkg::S_SQ_Y;
            end
         end
         ehdd_pkg::S_SQ_Y: begin
            sq_y_in  = mul_res;
            state_in = ehdd_pkg::S_SUM;
         end
         ehdd_pkg::S_SUM: begin
            root_start = 1'b1;
            state_in   = ehdd_pkg::S_ROOT;
         end
         ehdd_pkg::S_ROOT: begin
            if (root_done) begin
               dist_in  = root_val;
               state_in = ehdd_pkg::S_DECIDE;
            end
         end
         ehdd_pkg::S_DECIDE: begin
            state_in = ehdd_pkg::S_IDLE;
            if (fire_ff) begin
               armed_in   = 1'b0;
               left_in    = '0;
               entered_in = 1'b1;
               q_in[0]    = '{event_code: ehdd_pkg::EV_ENTER, proximity: '0,
                              last_of_run: 1'b0};
               q_in[1]    = '{event_code: ehdd_pkg::EV_PROX, proximity: capped,
                              last_of_run: 1'b1};
               qcnt_in    = 2'd2;
               state_in   = ehdd_pkg::S_EMIT;
            end else if (hot) begin
               if (entered_ff) begin
                  q_in[0]  = '{event_code: ehdd_pkg::EV_PROX, proximity: capped,
                               last_of_run: 1'b1};
                  qcnt_in  = 2'd1;
                  state_in = ehdd_pkg::S_EMIT;
               end else if (!armed_ff) begin
                  armed_in = 1'b1;
                  left_in  = dwell_ff;
                  ax_in    = pt_x_ff;
                  ay_in    = pt_y_ff;
               end
            end else begin
               armed_in = 1'b0;
               if (entered_ff) begin
                  entered_in = 1'b0;
                  q_in[0]    = '{event_code: ehdd_pkg::EV_LEAVE, proximity: '0,
                                 last_of_run: 1'b1};
                  qcnt_in    = 2'd1;
                  state_in   = ehdd_pkg::S_EMIT;
               end
            end
         end
         ehdd_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = q_ff[0];
               q_in[0]      = q_ff[1];
               qcnt_in      = qcnt_ff - 1'b1;
               if (qcnt_ff == 2'd1) begin
                  state_in = ehdd_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ehdd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_x_ff    <= '0;
         trig_y_ff    <= '0;
         trig_w_ff    <= '0;
         trig_h_ff    <= '0;
         thresh_ff    <= '0;
         dwell_ff     <= '0;
         origin_ff    <= '0;
         size_ff      <= '0;
         state_ff     <= ehdd_pkg::S_IDLE;
         entered_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         gone_ff      <= 1'b0;
         left_ff      <= '0;
         ax_ff        <= '0;
         ay_ff        <= '0;
         qcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         trig_x_ff    <= trig_x_in;
         trig_y_ff    <= trig_y_in;
         trig_w_ff    <= trig_w_in;
         trig_h_ff    <= trig_h_in;
         thresh_ff    <= thresh_in;
         dwell_ff     <= dwell_in;
         origin_ff    <= origin_in;
         size_ff      <= size_in;
         state_ff     <= state_in;
         entered_ff   <= entered_in;
         armed_ff     <= armed_in;
         gone_ff      <= gone_in;
         left_ff      <= left_in;
         ax_ff        <= ax_in;
         ay_ff        <= ay_in;
         qcnt_ff      <= qcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fire_ff     <= fire_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      lo_x_ff     <= lo_x_in;
      hi_x_ff     <= hi_x_in;
      lo_y_ff     <= lo_y_in;
      hi_y_ff     <= hi_y_in;
      rx_ff       <= rx_in;
      by_ff       <= by_in;
      oxh_ff      <= oxh_in;
      oyh_ff      <= oyh_in;
      box_ff      <= box_in;
      dxr_ff      <= dxr_in;
      dyr_ff      <= dyr_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sq_x_ff     <= sq_x_in;
      sq_y_ff     <= sq_y_in;
      dist_ff     <= dist_in;
      q_ff[0]     <= q_in[0];
      q_ff[1]     <= q_in[1];
      rsp_item_ff <= rsp_item_in;
   end

   assign req_ch.ready       = req_ready && !reset;
   assign csr_ch.ready       = !reset;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_code  = rsp_item_ff.event_code;
   assign rsp_ch.proximity   = rsp_item_ff.proximity;
   assign rsp_ch.last_of_run = rsp_item_ff.last_of_run;

endmodule
